// File: rtl/ttfb_pkg.sv
// ----------------------------------------------------------------------------
// ttfb_pkg
// Shared constants, codes and the 3x5 font for the text framebuffer renderer.
// ----------------------------------------------------------------------------
package ttfb_pkg;

    // Default geometry
    localparam int TTFB_WIDTH = 128;
    localparam int TTFB_PAGES = 8;

    // Field widths
    localparam int FUNC_W   = 2;
    localparam int ROW_W    = 4;
    localparam int CHAR_W   = 8;
    localparam int ADDR_W   = 10;
    localparam int STATUS_W = 2;
    localparam int BYTE_W   = 8;

    // Font geometry
    localparam int GLYPH_COLS    = 3;
    localparam int GLYPH_ROWS    = 5;
    localparam int GLYPH_ADVANCE = 4;
    localparam int GLYPH_BITS    = GLYPH_COLS * GLYPH_ROWS;

    // Item kinds
    localparam logic [FUNC_W-1:0] FN_CLEAR    = 2'd0;
    localparam logic [FUNC_W-1:0] FN_OPEN_ROW = 2'd1;
    localparam logic [FUNC_W-1:0] FN_PLACE    = 2'd2;
    localparam logic [FUNC_W-1:0] FN_READ     = 2'd3;

    // Result status
    localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID_STATE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID_ARG   = 2'd2;

    typedef logic [GLYPH_BITS-1:0] glyph_t;

    // Pack five pixel lines; line r sits in bits [3r+2:3r], bit c is column c
    function automatic glyph_t gl(input int l0, input int l1, input int l2,
                                  input int l3, input int l4);
        gl = {3'(l4), 3'(l3), 3'(l2), 3'(l1), 3'(l0)};
    endfunction

    // Character generator: fold lower case, unknown codes map to '?'
    function automatic glyph_t glyph_lines(input logic [CHAR_W-1:0] code);
        logic [CHAR_W-1:0] up;
        glyph_t            g;
        up = code;
        if (code >= 8'h61 && code <= 8'h7A)
            up = code - 8'h20;
        case (up)
            8'h20: g = gl(0, 0, 0, 0, 0); // space
            8'h2D: g = gl(0, 0, 7, 0, 0); // -
            8'h2E: g = gl(0, 0, 0, 0, 2); // .
            8'h3A: g = gl(0, 2, 0, 2, 0); // :
            8'h2F: g = gl(4, 4, 2, 1, 1); // /
            8'h3E: g = gl(1, 2, 4, 2, 1); // >
            8'h30: g = gl(7, 5, 5, 5, 7);
            8'h31: g = gl(2, 3, 2, 2, 7);
            8'h32: g = gl(7, 4, 7, 1, 7);
            8'h33: g = gl(7, 4, 7, 4, 7);
            8'h34: g = gl(5, 5, 7, 4, 4);
            8'h35: g = gl(7, 1, 7, 4, 7);
            8'h36: g = gl(7, 1, 7, 5, 7);
            8'h37: g = gl(7, 4, 4, 2, 2);
            8'h38: g = gl(7, 5, 7, 5, 7);
            8'h39: g = gl(7, 5, 7, 4, 7);
            8'h41: g = gl(2, 5, 7, 5, 5);
            8'h42: g = gl(3, 5, 3, 5, 3);
            8'h43: g = gl(6, 1, 1, 1, 6);
            8'h44: g = gl(3, 5, 5, 5, 3);
            8'h45: g = gl(7, 1, 3, 1, 7);
            8'h46: g = gl(7, 1, 3, 1, 1);
            8'h47: g = gl(6, 1, 5, 5, 6);
            8'h48: g = gl(5, 5, 7, 5, 5);
            8'h49: g = gl(7, 2, 2, 2, 7);
            8'h4A: g = gl(4, 4, 4, 5, 7);
            8'h4B: g = gl(5, 5, 3, 5, 5);
            8'h4C: g = gl(1, 1, 1, 1, 7);
            8'h4D: g = gl(5, 7, 7, 5, 5);
            8'h4E: g = gl(5, 7, 7, 7, 5);
            8'h4F: g = gl(7, 5, 5, 5, 7);
            8'h50: g = gl(7, 5, 7, 1, 1);
            8'h51: g = gl(7, 5, 5, 7, 4);
            8'h52: g = gl(3, 5, 3, 5, 5);
            8'h53: g = gl(6, 1, 7, 4, 3);
            8'h54: g = gl(7, 2, 2, 2, 2);
            8'h55: g = gl(5, 5, 5, 5, 7);
            8'h56: g = gl(5, 5, 5, 5, 2);
            8'h57: g = gl(5, 5, 7, 7, 5);
            8'h58: g = gl(5, 5, 2, 5, 5);
            8'h59: g = gl(5, 5, 2, 2, 2);
            8'h5A: g = gl(7, 4, 2, 1, 7);
            default: g = gl(7, 4, 2, 0, 2); // '?' fallback
        endcase
        glyph_lines = g;
    endfunction

endpackage

// File: rtl/ttfb_glyph.sv
// ----------------------------------------------------------------------------
// ttfb_glyph
// Registered character generator: looks up a glyph and hands out one
// column byte at a time (bit k = pixel row k).
// ----------------------------------------------------------------------------
module ttfb_glyph
    import ttfb_pkg::*;
(
    input  logic              clk,
    input  logic              load,
    input  logic [CHAR_W-1:0] char_code,
    input  logic [1:0]        col_sel,
    output logic [BYTE_W-1:0] col_byte
);

    glyph_t glyph_reg;

    // Capture the glyph when a character is taken
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            glyph_reg <= glyph_lines(char_code);
        end
    end

    // Transpose: pick column col_sel out of each pixel line
    always_comb
    begin
        col_byte = '0;
        for (int r = 0; r < GLYPH_ROWS; r++)
        begin
            case (col_sel)
                2'd0:    col_byte[r] = glyph_reg[GLYPH_COLS*r];
                2'd1:    col_byte[r] = glyph_reg[GLYPH_COLS*r + 1];
                2'd2:    col_byte[r] = glyph_reg[GLYPH_COLS*r + 2];
                default: col_byte[r] = 1'b0;
            endcase
        end
    end

endmodule

// File: rtl/text_to_framebuffer_renderer.sv
// ----------------------------------------------------------------------------
// text_to_framebuffer_renderer
// Page-organized monochrome framebuffer with a 3x5 text generator.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  in      | sink      | in_valid/in_stall  | func, row, char_code, read_address
//  out     | source    | out_valid/out_stall| status, placed, read_data
//  cfg     | sink      | cfg_valid/cfg_ready| cfg_data (display_enabled)
//
//  One item at a time. Place character: three column writes, then result.
//  Read byte: registered memory read, then result. Open row clears the
//  row's WIDTH bytes, clear all clears all WIDTH*PAGES bytes (one byte
//  cleared per cycle). Refused items go straight to the result.
//  After reset all WIDTH*PAGES bytes are cleared with in_stall high.
//  A result waiting in the output register does not block the next transfer.
// ----------------------------------------------------------------------------
module text_to_framebuffer_renderer
    import ttfb_pkg::*;
#(
    parameter int WIDTH = TTFB_WIDTH,
    parameter int PAGES = TTFB_PAGES
)
(
    input  logic                clk,
    input  logic                rst_n,
    // item input
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [FUNC_W-1:0]   func,
    input  logic [ROW_W-1:0]    row,
    input  logic [CHAR_W-1:0]   char_code,
    input  logic [ADDR_W-1:0]   read_address,
    // result output
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic                placed,
    output logic [BYTE_W-1:0]   read_data,
    // configuration
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);

    localparam int STORE = WIDTH * PAGES;
    localparam int AW    = $clog2(STORE);
    localparam int AW1   = AW + 1;
    localparam int XW    = ((AW > ADDR_W) ? AW : ADDR_W) + 1;
    localparam int CW    = $clog2(WIDTH + 2);
    localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SWEEP  = 3'd2;
    localparam logic [2:0] S_WRITE  = 3'd3;
    localparam logic [2:0] S_READ   = 3'd4;
    localparam logic [2:0] S_RDWAIT = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    // control state
    logic [2:0]          state_reg, state_next;
    logic [AW-1:0]       ptr_reg, ptr_next;
    logic [AW-1:0]       end_reg, end_next;
    logic [1:0]          wcnt_reg, wcnt_next;
    logic                out_valid_reg, out_valid_next;
    logic                enabled_reg, enabled_next;
    logic [PW-1:0]       page_reg, page_next;
    logic [CW-1:0]       col_reg, col_next;
    logic                page_open_reg, page_open_next;

    // payload
    logic [AW-1:0]       addr_reg, addr_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                res_placed_reg, res_placed_next;
    logic [BYTE_W-1:0]   res_data_reg, res_data_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic                out_placed_reg, out_placed_next;
    logic [BYTE_W-1:0]   out_data_reg, out_data_next;

    // frame memory
    logic [BYTE_W-1:0]   mem [STORE];
    logic [BYTE_W-1:0]   mem_q;
    logic                mem_we;
    logic [BYTE_W-1:0]   mem_wdata;

    // glyph generator
    logic                glyph_load;
    logic [BYTE_W-1:0]   glyph_byte;

    // address arithmetic
    logic [AW1-1:0]      row_base_w;
    logic [AW1-1:0]      row_end_w;
    logic [AW1-1:0]      cur_base_w;
    logic [XW-1:0]       rd_addr_x;
    logic                row_ok;
    logic                rd_ok;

    ttfb_glyph u_glyph (
        .clk       (clk),
        .load      (glyph_load),
        .char_code (char_code),
        .col_sel   (wcnt_reg),
        .col_byte  (glyph_byte)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign placed    = out_placed_reg;
    assign read_data = out_data_reg;

    // Page bases and range checks
    always_comb
    begin
        row_base_w = AW1'(row) * AW1'(WIDTH);
        row_end_w  = row_base_w + AW1'(WIDTH - 1);
        cur_base_w = AW1'(page_reg) * AW1'(WIDTH) + AW1'(col_reg);
        rd_addr_x  = XW'(read_address);
        row_ok     = ({1'b0, row} < 5'(PAGES));
        rd_ok      = (rd_addr_x < XW'(STORE));
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        end_next        = end_reg;
        wcnt_next       = wcnt_reg;
        enabled_next    = enabled_reg;
        page_next       = page_reg;
        col_next        = col_reg;
        page_open_next  = page_open_reg;
        addr_next       = addr_reg;
        res_status_next = res_status_reg;
        res_placed_next = res_placed_reg;
        res_data_next   = res_data_reg;
        out_status_next = out_status_reg;
        out_placed_next = out_placed_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && out_stall;
        mem_we          = 1'b0;
        mem_wdata       = '0;
        glyph_load      = 1'b0;

        if (cfg_valid && cfg_ready)
            enabled_next = cfg_data;

        unique case (state_reg)
            S_INIT:
            begin
                mem_we = 1'b1;
                if (ptr_reg == end_reg)
                    state_next = S_IDLE;
                else
                    ptr_next = ptr_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_status_next = ST_OK;
                    res_placed_next = 1'b0;
                    res_data_next   = '0;
                    state_next      = S_FINISH;
                    if (!enabled_reg)
                    begin
                        res_status_next = ST_INVALID_STATE;
                    end
                    else
                    begin
                        unique case (func)
                            FN_CLEAR:
                            begin
                                ptr_next   = '0;
                                end_next   = AW'(STORE - 1);
                                state_next = S_SWEEP;
                            end
                            FN_OPEN_ROW:
                            begin
                                if (!row_ok)
                                begin
                                    res_status_next = ST_INVALID_ARG;
                                end
                                else
                                begin
                                    ptr_next       = row_base_w[AW-1:0];
                                    end_next       = row_end_w[AW-1:0];
                                    page_next      = row[PW-1:0];
                                    col_next       = '0;
                                    page_open_next = 1'b1;
                                    state_next     = S_SWEEP;
                                end
                            end
                            FN_PLACE:
                            begin
                                if (!page_open_reg)
                                begin
                                    res_status_next = ST_INVALID_ARG;
                                end
                                else if (col_reg < CW'(WIDTH - GLYPH_COLS))
                                begin
                                    ptr_next        = cur_base_w[AW-1:0];
                                    wcnt_next       = '0;
                                    col_next        = col_reg + CW'(GLYPH_ADVANCE);
                                    res_placed_next = 1'b1;
                                    glyph_load      = 1'b1;
                                    state_next      = S_WRITE;
                                end
                            end
                            FN_READ:
                            begin
                                if (rd_ok)
                                begin
                                    addr_next  = rd_addr_x[AW-1:0];
                                    state_next = S_READ;
                                end
                                else
                                begin
                                    res_status_next = ST_INVALID_ARG;
                                end
                            end
                            default:
                            begin
                                state_next = S_FINISH;
                            end
                        endcase
                    end
                end
            end
            S_SWEEP:
            begin
                mem_we = 1'b1;
                if (ptr_reg == end_reg)
                    state_next = S_FINISH;
                else
                    ptr_next = ptr_reg + 1'b1;
            end
            S_WRITE:
            begin
                mem_we    = 1'b1;
                mem_wdata = glyph_byte;
                ptr_next  = ptr_reg + 1'b1;
                wcnt_next = wcnt_reg + 1'b1;
                if (wcnt_reg == 2'(GLYPH_COLS - 1))
                    state_next = S_FINISH;
            end
            S_READ:
            begin
                state_next = S_RDWAIT;
            end
            S_RDWAIT:
            begin
                res_data_next = mem_q;
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                // hand over once the output register is free or draining
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_placed_next = res_placed_reg;
                    out_data_next   = res_data_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            ptr_reg       <= '0;
            end_reg       <= AW'(STORE - 1);
            wcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            enabled_reg   <= 1'b0;
            page_reg      <= '0;
            col_reg       <= '0;
            page_open_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            end_reg       <= end_next;
            wcnt_reg      <= wcnt_next;
            out_valid_reg <= out_valid_next;
            enabled_reg   <= enabled_next;
            page_reg      <= page_next;
            col_reg       <= col_next;
            page_open_reg <= page_open_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        res_status_reg <= res_status_next;
        res_placed_reg <= res_placed_next;
        res_data_reg   <= res_data_next;
        out_status_reg <= out_status_next;
        out_placed_reg <= out_placed_next;
        out_data_reg   <= out_data_next;
    end

    // Frame memory: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[ptr_reg] <= mem_wdata;
        end
        mem_q <= mem[addr_reg];
    end

endmodule
